// ----- rtl/lsms_pkg.sv -----
// Package for the load/store-multiple sequencer.
// Holds the queued request type, result kind codes, sequencer states and constants.
// No dependencies.
package lsms_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0]  PC_INDEX   = 4'd15;
  localparam logic [31:0] EMPTY_STEP = 32'h0000_0040;
  localparam logic [31:0] WORD_STEP  = 32'd4;
  localparam logic [31:0] PC_ADJUST  = 32'd2;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WBACK = 2'd2
  } lsms_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_XFER  = 2'd1,
    BK_WBACK = 2'd2
  } lsms_state_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic        is_store;
    logic [2:0]  base_reg;
    logic [7:0]  reg_list;
    logic        list_empty;
    logic [31:0] base_value;
    logic [31:0] final_base;
    logic [31:0] pc_store;
  } lsms_item_t;

endpackage

// ----- rtl/load_store_multiple_sequencer_unit.sv -----
// Top level of the Thumb load/store-multiple-increment-after sequencer.
// Instantiates lsms_front, lsms_queue and lsms_back; depends on lsms_pkg.
//
// A request (start high while busy is low) describes one LDMIA or STMIA. The
// block emits one result per listed register in ascending order, then a final
// base writeback with out_last set; an empty list gives a single PC transfer.
// Results appear on the out_ ports for one cycle each, marked by out_valid, and
// the receiver cannot stall them. Each request holds the back-end sequencer
// for its transfers and the writeback, one result per cycle, after passing
// through a queue entry and the back-end state registers. Up to QUEUE_DEPTH
// requests wait in the queue; busy is high while it is full.
module load_store_multiple_sequencer_unit #(
  parameter int unsigned QUEUE_DEPTH = lsms_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_op,
  input  logic [2:0]  in_base_reg,
  input  logic [7:0]  in_reg_list,
  input  logic [31:0] in_base_value,
  input  logic [31:0] in_pc_value,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [31:0] out_address,
  output logic [3:0]  out_reg_index,
  output logic        out_use_value,
  output logic [31:0] out_value,
  output logic        out_last
);
  import lsms_pkg::*;

  lsms_item_t front_item;
  lsms_item_t head_item;
  logic       q_full;
  logic       q_not_empty;
  logic       q_pop;

  assign busy = q_full;

  lsms_front u_front (
    .op         (in_op),
    .base_reg   (in_base_reg),
    .reg_list   (in_reg_list),
    .base_value (in_base_value),
    .pc_value   (in_pc_value),
    .item       (front_item)
  );

  lsms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (start),
    .push_item (front_item),
    .pop       (q_pop),
    .head_item (head_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  lsms_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_item     (head_item),
    .head_valid    (q_not_empty),
    .pop           (q_pop),
    .res_valid     (out_valid),
    .res_kind      (out_kind),
    .res_address   (out_address),
    .res_reg_index (out_reg_index),
    .res_use_value (out_use_value),
    .res_value     (out_value),
    .res_last      (out_last)
  );

endmodule

// ----- rtl/lsms_front.sv -----
// Front end of the load/store-multiple sequencer: classifies a request.
// Computes the written-back base and the stored PC value. Depends on lsms_pkg.
module lsms_front (
  input  logic               op,
  input  logic [2:0]         base_reg,
  input  logic [7:0]         reg_list,
  input  logic [31:0]        base_value,
  input  logic [31:0]        pc_value,
  output lsms_pkg::lsms_item_t item
);
  import lsms_pkg::*;

  logic [3:0]  reg_count;
  logic [31:0] step;

  always_comb begin
    reg_count = 4'd0;
    for (int i = 0; i < 8; i++) begin
      reg_count = reg_count + {3'b000, reg_list[i]};
    end
  end

  // An empty list moves the base by a fixed sixteen words.
  assign step = (reg_list == 8'h00) ? EMPTY_STEP : {26'd0, reg_count, 2'b00};

  always_comb begin
    item.is_store   = op;
    item.base_reg   = base_reg;
    item.reg_list   = reg_list;
    item.list_empty = (reg_list == 8'h00);
    item.base_value = base_value;
    item.final_base = base_value + step;
    item.pc_store   = pc_value + PC_ADJUST;
  end

endmodule

// ----- rtl/lsms_queue.sv -----
// Short register queue between the front and back ends of the sequencer.
// Stores classified requests; depth set by DEPTH. Depends on lsms_pkg.
module lsms_queue #(
  parameter int unsigned DEPTH = lsms_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lsms_pkg::lsms_item_t push_item,
  input  logic                 pop,
  output lsms_pkg::lsms_item_t head_item,
  output logic                 not_empty,
  output logic                 full
);
  import lsms_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lsms_item_t    entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_item = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/lsms_back.sv -----
// Back end of the load/store-multiple sequencer: walks the register list.
// Emits one registered result per cycle from the queued request. Depends on lsms_pkg.
module lsms_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsms_pkg::lsms_item_t head_item,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 res_valid,
  output logic [1:0]           res_kind,
  output logic [31:0]          res_address,
  output logic [3:0]           res_reg_index,
  output logic                 res_use_value,
  output logic [31:0]          res_value,
  output logic                 res_last
);
  import lsms_pkg::*;

  lsms_state_t state_r, state_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        first_r, first_nxt;
  logic        is_store_r, is_store_nxt;
  logic        empty_r, empty_nxt;
  logic [2:0]  base_reg_r, base_reg_nxt;
  logic [31:0] final_r, final_nxt;
  logic [31:0] pc_store_r, pc_store_nxt;

  logic        valid_r, valid_nxt;
  lsms_kind_t  kind_r, kind_nxt;
  logic [31:0] address_r, address_nxt;
  logic [3:0]  reg_index_r, reg_index_nxt;
  logic        use_value_r, use_value_nxt;
  logic [31:0] value_r, value_nxt;
  logic        last_r, last_nxt;

  logic [2:0]  low_idx;
  logic [7:0]  rest_mask;
  logic        final_xfer;
  logic        override;

  always_comb begin
    low_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_r[i]) begin
        low_idx = 3'(i);
      end
    end
  end

  assign rest_mask  = mask_r & (mask_r - 8'd1);
  assign final_xfer = empty_r || (rest_mask == 8'h00);
  // A store of the base register after the first transfer carries the new base.
  assign override   = is_store_r && !first_r && (low_idx == base_reg_r);

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    addr_nxt      = addr_r;
    first_nxt     = first_r;
    is_store_nxt  = is_store_r;
    empty_nxt     = empty_r;
    base_reg_nxt  = base_reg_r;
    final_nxt     = final_r;
    pc_store_nxt  = pc_store_r;
    pop           = 1'b0;
    valid_nxt     = 1'b0;
    kind_nxt      = KIND_WBACK;
    address_nxt   = 32'd0;
    reg_index_nxt = 4'd0;
    use_value_nxt = 1'b0;
    value_nxt     = 32'd0;
    last_nxt      = 1'b0;

    case (state_r)
      BK_XFER: begin
        valid_nxt   = 1'b1;
        kind_nxt    = is_store_r ? KIND_WRITE : KIND_READ;
        address_nxt = addr_r;
        if (empty_r) begin
          reg_index_nxt = PC_INDEX;
          use_value_nxt = is_store_r;
          value_nxt     = is_store_r ? pc_store_r : 32'd0;
        end else begin
          reg_index_nxt = {1'b0, low_idx};
          use_value_nxt = override;
          value_nxt     = override ? final_r : 32'd0;
        end
        mask_nxt  = rest_mask;
        addr_nxt  = addr_r + WORD_STEP;
        first_nxt = 1'b0;
        if (final_xfer) begin
          state_nxt = BK_WBACK;
        end
      end
      BK_WBACK: begin
        valid_nxt     = 1'b1;
        kind_nxt      = KIND_WBACK;
        reg_index_nxt = {1'b0, base_reg_r};
        use_value_nxt = 1'b1;
        value_nxt     = final_r;
        last_nxt      = 1'b1;
        state_nxt     = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    // The next request is loaded while the writeback goes out.
    if ((state_r == BK_IDLE || state_r == BK_WBACK) && head_valid) begin
      pop          = 1'b1;
      state_nxt    = BK_XFER;
      mask_nxt     = head_item.reg_list;
      addr_nxt     = head_item.base_value;
      first_nxt    = 1'b1;
      is_store_nxt = head_item.is_store;
      empty_nxt    = head_item.list_empty;
      base_reg_nxt = head_item.base_reg;
      final_nxt    = head_item.final_base;
      pc_store_nxt = head_item.pc_store;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r      <= mask_nxt;
    addr_r      <= addr_nxt;
    first_r     <= first_nxt;
    is_store_r  <= is_store_nxt;
    empty_r     <= empty_nxt;
    base_reg_r  <= base_reg_nxt;
    final_r     <= final_nxt;
    pc_store_r  <= pc_store_nxt;
    kind_r      <= kind_nxt;
    address_r   <= address_nxt;
    reg_index_r <= reg_index_nxt;
    use_value_r <= use_value_nxt;
    value_r     <= value_nxt;
    last_r      <= last_nxt;
  end

  assign res_valid     = valid_r;
  assign res_kind      = kind_r;
  assign res_address   = address_r;
  assign res_reg_index = reg_index_r;
  assign res_use_value = use_value_r;
  assign res_value     = value_r;
  assign res_last      = last_r;

endmodule
